// ----- hw/rtl/vcf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual circuit formation package
// Types, codes and widths shared by the channel interfaces and the FSM.
// ----------------------------------------------------------------------------
package vcf_pkg;

  // Width of the time base used for the retransmission timer.
  localparam int unsigned TIME_WIDTH = 32;
  // Width at which elapsed time and the timeout are compared.
  localparam int unsigned CMP_WIDTH  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  localparam int unsigned CFG_IDX_WIDTH  = 2;
  localparam int unsigned CFG_DATA_WIDTH = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_REISSUE_CAP = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RESEND_WAIT = 2'd1;

  localparam logic [7:0]  REISSUE_CAP_RST = 8'd8;
  localparam logic [31:0] RESEND_WAIT_RST = 32'd1000;

  // Operations.
  localparam logic [1:0] OP_OPEN     = 2'd0;
  localparam logic [1:0] OP_RESPONSE = 2'd1;
  localparam logic [1:0] OP_TIMER    = 2'd2;
  localparam logic [1:0] OP_REINIT   = 2'd3;

  // Peer events.
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_STACK = 2'd1;
  localparam logic [1:0] EV_ACK   = 2'd2;
  localparam logic [1:0] EV_OTHER = 2'd3;

  // Circuit states.
  localparam logic [1:0] ST_CLOSED         = 2'd0;
  localparam logic [1:0] ST_START_SENT     = 2'd1;
  localparam logic [1:0] ST_START_RECEIVED = 2'd2;
  localparam logic [1:0] ST_OPEN           = 2'd3;

  // Actions.
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_STACK   = 3'd2;
  localparam logic [2:0] ACT_ACK     = 3'd3;
  localparam logic [2:0] ACT_ABANDON = 3'd4;

  // Packet last sent, kept for reissue.
  localparam logic [1:0] SENT_NONE  = 2'd0;
  localparam logic [1:0] SENT_START = 2'd1;
  localparam logic [1:0] SENT_STACK = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  peer_event;
    logic [31:0] now_time;
  } vcf_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  circuit_state;
    logic        is_abandoned;
    logic [7:0]  retry_count;
    logic [15:0] reissue_total;
    logic [15:0] implied_ack_total;
  } vcf_result_t;

  typedef struct packed {
    logic [CFG_IDX_WIDTH-1:0]  index;
    logic [CFG_DATA_WIDTH-1:0] value;
  } vcf_cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vcf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual circuit formation channels
// Valid/ready interfaces for the item, result and configuration channels.
// ----------------------------------------------------------------------------
interface vcf_in_if import vcf_pkg::*; ();
  logic      valid;
  logic      ready;
  vcf_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcf_out_if import vcf_pkg::*; ();
  logic        valid;
  logic        ready;
  vcf_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcf_cfg_if import vcf_pkg::*; ();
  logic     valid;
  logic     ready;
  vcf_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/virtual_circuit_formation_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual circuit formation FSM
// START/STACK/ACK handshake that forms a virtual circuit, one result per item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                                    | Transfer
//  in_i    | sink      | operation, peer_event, now_time            | valid & ready
//  out_o   | source    | action, state, abandoned flag, counters    | valid & ready
//  cfg_i   | sink      | index (0 reissue cap, 1 resend wait), value | valid & ready
//
// An item is held in the input register, then evaluated against the circuit
// state and written to the result register; one item is taken every cycle
// while the result is not stalled. Reset brings the state to closed and the
// registers to a retry limit of 8 and a timeout of 1000 ms. A stalled result
// holds the pipeline; the input stays ready while its register is empty.
// ----------------------------------------------------------------------------
module virtual_circuit_formation_fsm import vcf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vcf_in_if.sink     in_i,
  vcf_out_if.source  out_o,
  vcf_cfg_if.sink    cfg_i
);

  // Configuration registers.
  logic [7:0]  reissue_cap_q;
  logic [31:0] resend_wait_q;

  // Input stage.
  logic      s1_valid_q;
  vcf_item_t s1_item_q;
  logic      s1_adv;

  // Result stage.
  logic        out_valid_q;
  vcf_result_t out_data_q, out_data_d;

  // Circuit state.
  logic [1:0]            vc_state_q, vc_state_d;
  logic [1:0]            last_sent_q, last_sent_d;
  logic                  timer_armed_q, timer_armed_d;
  logic [TIME_WIDTH-1:0] timer_start_q, timer_start_d;
  logic [7:0]            retries_q, retries_d;
  logic [15:0]           reissues_q, reissues_d;
  logic [15:0]           implied_acks_q, implied_acks_d;
  logic                  abandoned_q, abandoned_d;
  logic [2:0]            act;

  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now_tw;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  expired;
  logic [7:0]            retries_inc;
  logic [15:0]           reissues_inc;
  logic [15:0]           implied_inc;
  logic                  limit_hit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reissue_cap_q <= REISSUE_CAP_RST;
      resend_wait_q <= RESEND_WAIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_REISSUE_CAP: reissue_cap_q <= cfg_i.data.value[7:0];
        CFG_RESEND_WAIT: resend_wait_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or drains.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  // Only the low TIME_WIDTH bits of the timestamp take part.
  assign now_ext = {32'd0, s1_item_q.now_time};
  assign now_tw  = now_ext[TIME_WIDTH-1:0];
  assign elapsed = now_tw - timer_start_q;
  assign expired = timer_armed_q && (now_tw >= timer_start_q) &&
                   (CMP_WIDTH'(elapsed) >= CMP_WIDTH'(resend_wait_q));

  assign retries_inc  = (retries_q == 8'hFF) ? retries_q : retries_q + 8'd1;
  assign reissues_inc = (reissues_q == 16'hFFFF) ? reissues_q : reissues_q + 16'd1;
  assign implied_inc  = (implied_acks_q == 16'hFFFF) ? implied_acks_q
                                                     : implied_acks_q + 16'd1;
  // The limit is tested against the count after this reissue.
  assign limit_hit    = (reissue_cap_q != 8'd0) && (retries_inc >= reissue_cap_q);

  always_comb begin
    vc_state_d     = vc_state_q;
    last_sent_d    = last_sent_q;
    timer_armed_d  = timer_armed_q;
    timer_start_d  = timer_start_q;
    retries_d      = retries_q;
    reissues_d     = reissues_q;
    implied_acks_d = implied_acks_q;
    abandoned_d    = abandoned_q;
    act            = ACT_NONE;

    if (s1_item_q.operation == OP_REINIT) begin
      vc_state_d     = ST_CLOSED;
      last_sent_d    = SENT_NONE;
      timer_armed_d  = 1'b0;
      timer_start_d  = '0;
      retries_d      = '0;
      reissues_d     = '0;
      implied_acks_d = '0;
      abandoned_d    = 1'b0;
    end else if (!abandoned_q) begin
      case (s1_item_q.operation)
        OP_OPEN: begin
          if (vc_state_q == ST_CLOSED) begin
            vc_state_d    = ST_START_SENT;
            last_sent_d   = SENT_START;
            timer_armed_d = 1'b1;
            timer_start_d = now_tw;
            retries_d     = '0;
            act           = ACT_START;
          end
        end
        OP_RESPONSE: begin
          case (vc_state_q)
            ST_START_SENT: begin
              case (s1_item_q.peer_event)
                EV_STACK: begin
                  vc_state_d    = ST_OPEN;
                  timer_armed_d = 1'b0;
                  retries_d     = '0;
                  act           = ACT_ACK;
                end
                EV_START: begin
                  vc_state_d    = ST_START_RECEIVED;
                  last_sent_d   = SENT_STACK;
                  timer_armed_d = 1'b1;
                  timer_start_d = now_tw;
                  retries_d     = '0;
                  act           = ACT_STACK;
                end
                EV_ACK: begin
                  // An ACK before our START was answered is unacceptable.
                  vc_state_d    = ST_CLOSED;
                  timer_armed_d = 1'b0;
                  abandoned_d   = 1'b1;
                  act           = ACT_ABANDON;
                end
                default: ;
              endcase
            end
            ST_START_RECEIVED: begin
              case (s1_item_q.peer_event)
                EV_STACK: begin
                  vc_state_d    = ST_OPEN;
                  timer_armed_d = 1'b0;
                  retries_d     = '0;
                  act           = ACT_ACK;
                end
                EV_ACK: begin
                  vc_state_d    = ST_OPEN;
                  timer_armed_d = 1'b0;
                  retries_d     = '0;
                end
                EV_START: begin
                  // A repeated START from the peer counts as a reissue.
                  retries_d     = retries_inc;
                  reissues_d    = reissues_inc;
                  timer_start_d = now_tw;
                  last_sent_d   = SENT_STACK;
                  if (limit_hit) begin
                    vc_state_d    = ST_CLOSED;
                    timer_armed_d = 1'b0;
                    abandoned_d   = 1'b1;
                    act           = ACT_ABANDON;
                  end else begin
                    timer_armed_d = 1'b1;
                    act           = ACT_STACK;
                  end
                end
                default: begin
                  // Any other circuit packet stands in for the ACK.
                  vc_state_d     = ST_OPEN;
                  timer_armed_d  = 1'b0;
                  retries_d      = '0;
                  implied_acks_d = implied_inc;
                end
              endcase
            end
            default: ;
          endcase
        end
        OP_TIMER: begin
          if (expired && (last_sent_q == SENT_START || last_sent_q == SENT_STACK)) begin
            retries_d  = retries_inc;
            reissues_d = reissues_inc;
            if (limit_hit) begin
              vc_state_d    = ST_CLOSED;
              timer_armed_d = 1'b0;
              abandoned_d   = 1'b1;
              act           = ACT_ABANDON;
            end else begin
              timer_start_d = now_tw;
              act           = (last_sent_q == SENT_START) ? ACT_START : ACT_STACK;
            end
          end
        end
        default: ;
      endcase
    end

    out_data_d.action            = act;
    out_data_d.circuit_state     = vc_state_d;
    out_data_d.is_abandoned      = abandoned_d;
    out_data_d.retry_count       = retries_d;
    out_data_d.reissue_total     = reissues_d;
    out_data_d.implied_ack_total = implied_acks_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_state_q     <= ST_CLOSED;
      last_sent_q    <= SENT_NONE;
      timer_armed_q  <= 1'b0;
      timer_start_q  <= '0;
      retries_q      <= '0;
      reissues_q     <= '0;
      implied_acks_q <= '0;
      abandoned_q    <= 1'b0;
    end else if (s1_adv) begin
      vc_state_q     <= vc_state_d;
      last_sent_q    <= last_sent_d;
      timer_armed_q  <= timer_armed_d;
      timer_start_q  <= timer_start_d;
      retries_q      <= retries_d;
      reissues_q     <= reissues_d;
      implied_acks_q <= implied_acks_d;
      abandoned_q    <= abandoned_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // An abandoned formation always leaves the circuit closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    abandoned_q |-> (vc_state_q == ST_CLOSED))
    else $error("abandoned while circuit not closed");

  // An open circuit never has a retransmission timer running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vc_state_q == ST_OPEN) |-> !timer_armed_q)
    else $error("timer armed in open state");

  // An abandon action is always reported with the abandoned flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.action == ACT_ABANDON) |-> out_data_q.is_abandoned)
    else $error("abandon action without abandoned flag");

  // An item in the input stage moves on when the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("item lost between input and result stage");

endmodule
`default_nettype wire
